// File: rtl/gsps_pkg.sv
`default_nettype none

package gsps_pkg;

  localparam int MAX_CHANNELS_DEF = 6;
  localparam int CH_W             = 3;
  localparam int MIN_W            = 10;
  localparam int SEC_W            = 16;
  localparam int VLV_W            = 6;
  localparam int SEC_PER_MIN      = 60;
  localparam int CFG_ADDR_W       = 5;
  localparam int CFG_DATA_W       = 32;

  typedef enum logic [2:0] {
    PH_ZERO    = 3'd0,
    PH_MEASURE = 3'd1,
    PH_PURGE   = 3'd2,
    PH_PAUSE   = 3'd3,
    PH_STOP    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_ZERO_MIN      = 3'd1,
    REG_MEASURE_MIN   = 3'd2,
    REG_PURGE_MIN     = 3'd3,
    REG_PAUSE_MIN     = 3'd4,
    REG_STOP_MIN      = 3'd5
  } reg_idx_t;

  localparam logic [CH_W-1:0]  CH_COUNT_RST = CH_W'(1);
  localparam logic [CH_W-1:0]  CH_FIRST     = CH_W'(1);
  localparam logic [MIN_W-1:0] MIN_RST      = '0;

  typedef struct packed {
    logic [CH_W-1:0]  channel_count;
    logic [MIN_W-1:0] zero_minutes;
    logic [MIN_W-1:0] measure_minutes;
    logic [MIN_W-1:0] purge_minutes;
    logic [MIN_W-1:0] pause_minutes;
    logic [MIN_W-1:0] stop_minutes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [CH_W-1:0]  channel;
    logic             zero_valve;
    logic             pump_on;
    logic [VLV_W-1:0] channel_valves;
    logic [SEC_W-1:0] seconds_left;
    logic             watchdog_kick;
    logic             phase_done;
  } result_t;

  // minutes to seconds, kept to the counter width
  function automatic logic [SEC_W-1:0] length_of(input logic [MIN_W-1:0] minutes);
    logic [SEC_W+MIN_W-1:0] prod;
    prod = (SEC_W+MIN_W)'(minutes) * (SEC_W+MIN_W)'(SEC_PER_MIN);
    return prod[SEC_W-1:0];
  endfunction

  // valve mask of a channel, bit n drives channel n+1
  function automatic logic [VLV_W-1:0] valve_bit(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0]  idx;
    logic [(1<<CH_W)-1:0] onehot;
    idx    = ch - CH_W'(1);
    onehot = {{((1<<CH_W)-1){1'b0}}, 1'b1} << idx;
    return onehot[VLV_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/gsps_in_if.sv
`default_nettype none

interface gsps_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

// File: rtl/gsps_out_if.sv
`default_nettype none

interface gsps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [2:0]  channel;
  logic        zero_valve;
  logic        pump_on;
  logic [5:0]  channel_valves;
  logic [15:0] seconds_left;
  logic        watchdog_kick;
  logic        phase_done;

  modport source (output valid, output phase, output channel, output zero_valve,
                  output pump_on, output channel_valves, output seconds_left,
                  output watchdog_kick, output phase_done, input ready);
  modport sink   (input valid, input phase, input channel, input zero_valve,
                  input pump_on, input channel_valves, input seconds_left,
                  input watchdog_kick, input phase_done, output ready);
endinterface

`default_nettype wire

// File: rtl/gas_sampling_phase_sequencer.sv
// Timed valve sequencer for a multi-point gas sampler. Each input word is one
// control evaluation carrying a one-second tick flag, and each evaluation
// returns exactly one result word with the phase, selected channel, valve and
// pump levels, seconds left, watchdog kick and phase-done flag as they stand
// after the update. Phases run zero, then measure/purge/pause for channels 1
// up to channel_count, then stop, and back to zero; each lasts its register
// value in minutes times 60 seconds, taken when the phase is entered. A phase
// of zero length ends at its first evaluation without driving anything, so
// the zero phase right after reset ends at once. One word is accepted per
// clock: the whole update is one pass of compare, decrement and phase select
// from the state registers into the result register, and a skid stage behind
// it keeps in_ch.ready high unless both the result register and the skid
// stage hold words the sink has not taken. Registers sit on an APB-style port
// at byte offsets 0 (channel_count, clamped to 1..MAX_CHANNELS), 4 (zero), 8
// (measure), 12 (purge), 16 (pause) and 20 (stop minutes); write them only
// while no evaluation is in flight.
`default_nettype none

module gas_sampling_phase_sequencer
  import gsps_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gsps_in_if.sink                    in_ch,
  gsps_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    in_ready;
  logic    in_accept;

  // register file, always ready
  gsps_cfg #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  assign in_accept = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // phase state and single-pass update
  gsps_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (in_accept),
    .tick   (in_ch.tick),
    .res    (step_res)
  );

  // result register plus skid word
  gsps_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (step_res),
    .push_ready (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_res)
  );

  assign out_ch.phase          = out_res.phase;
  assign out_ch.channel        = out_res.channel;
  assign out_ch.zero_valve     = out_res.zero_valve;
  assign out_ch.pump_on        = out_res.pump_on;
  assign out_ch.channel_valves = out_res.channel_valves;
  assign out_ch.seconds_left   = out_res.seconds_left;
  assign out_ch.watchdog_kick  = out_res.watchdog_kick;
  assign out_ch.phase_done     = out_res.phase_done;

endmodule

`default_nettype wire

// File: rtl/gsps_cfg.sv
`default_nettype none

module gsps_cfg
  import gsps_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output cfg_t                       cfg
);

  cfg_t            cfg_r;
  cfg_t            cfg_nxt;
  logic [2:0]      idx;
  logic            wr_en;
  logic [CH_W-1:0] count_clamped;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    count_clamped = pwdata[CH_W-1:0];
    if (count_clamped == '0) begin
      count_clamped = CH_W'(1);
    end
    if (32'(count_clamped) > MAX_CHANNELS) begin
      count_clamped = CH_W'(MAX_CHANNELS);
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_CHANNEL_COUNT: cfg_nxt.channel_count   = count_clamped;
        REG_ZERO_MIN:      cfg_nxt.zero_minutes    = pwdata[MIN_W-1:0];
        REG_MEASURE_MIN:   cfg_nxt.measure_minutes = pwdata[MIN_W-1:0];
        REG_PURGE_MIN:     cfg_nxt.purge_minutes   = pwdata[MIN_W-1:0];
        REG_PAUSE_MIN:     cfg_nxt.pause_minutes   = pwdata[MIN_W-1:0];
        REG_STOP_MIN:      cfg_nxt.stop_minutes    = pwdata[MIN_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count   <= CH_COUNT_RST;
      cfg_r.zero_minutes    <= MIN_RST;
      cfg_r.measure_minutes <= MIN_RST;
      cfg_r.purge_minutes   <= MIN_RST;
      cfg_r.pause_minutes   <= MIN_RST;
      cfg_r.stop_minutes    <= MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_CHANNEL_COUNT: prdata = CFG_DATA_W'(cfg_r.channel_count);
      REG_ZERO_MIN:      prdata = CFG_DATA_W'(cfg_r.zero_minutes);
      REG_MEASURE_MIN:   prdata = CFG_DATA_W'(cfg_r.measure_minutes);
      REG_PURGE_MIN:     prdata = CFG_DATA_W'(cfg_r.purge_minutes);
      REG_PAUSE_MIN:     prdata = CFG_DATA_W'(cfg_r.pause_minutes);
      REG_STOP_MIN:      prdata = CFG_DATA_W'(cfg_r.stop_minutes);
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/gsps_core.sv
`default_nettype none

module gsps_core
  import gsps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic accept,
  input  wire logic tick,
  output result_t   res
);

  phase_t           phase_r,       phase_nxt;
  logic [CH_W-1:0]  channel_r,     channel_nxt;
  logic [SEC_W-1:0] remaining_r,   remaining_nxt;
  logic             entered_r,     entered_nxt;
  logic             zero_valve_r,  zero_valve_nxt;
  logic             pump_r,        pump_nxt;
  logic [VLV_W-1:0] valves_r,      valves_nxt;
  logic             kick;
  logic             done;

  always_comb begin
    phase_nxt      = phase_r;
    channel_nxt    = channel_r;
    remaining_nxt  = remaining_r;
    entered_nxt    = entered_r;
    zero_valve_nxt = zero_valve_r;
    pump_nxt       = pump_r;
    valves_nxt     = valves_r;
    kick           = 1'b0;
    done           = 1'b0;

    if (remaining_r != '0) begin
      if (!entered_r) begin
        // first evaluation in the phase drives its outputs
        case (phase_r)
          PH_ZERO, PH_PURGE: begin
            zero_valve_nxt = 1'b1;
            pump_nxt       = 1'b1;
          end
          PH_MEASURE: begin
            valves_nxt = valves_r | valve_bit(channel_r);
            pump_nxt   = 1'b1;
          end
          default: begin
            zero_valve_nxt = 1'b0;
            pump_nxt       = 1'b0;
          end
        endcase
        entered_nxt = 1'b1;
      end else begin
        kick = 1'b1;
      end
      if (tick) begin
        remaining_nxt = remaining_r - SEC_W'(1);
      end
    end else begin
      // counter expired: close, reload and advance
      done        = 1'b1;
      entered_nxt = 1'b0;
      case (phase_r)
        PH_ZERO: begin
          zero_valve_nxt = 1'b0;
          pump_nxt       = 1'b0;
          phase_nxt      = PH_MEASURE;
          remaining_nxt  = length_of(cfg.measure_minutes);
        end
        PH_MEASURE: begin
          valves_nxt    = valves_r & ~valve_bit(channel_r);
          pump_nxt      = 1'b0;
          phase_nxt     = PH_PURGE;
          remaining_nxt = length_of(cfg.purge_minutes);
        end
        PH_PURGE: begin
          zero_valve_nxt = 1'b0;
          pump_nxt       = 1'b0;
          phase_nxt      = PH_PAUSE;
          remaining_nxt  = length_of(cfg.pause_minutes);
        end
        PH_PAUSE: begin
          if (channel_r >= cfg.channel_count) begin
            channel_nxt   = CH_FIRST;
            phase_nxt     = PH_STOP;
            remaining_nxt = length_of(cfg.stop_minutes);
          end else begin
            channel_nxt   = channel_r + CH_W'(1);
            phase_nxt     = PH_MEASURE;
            remaining_nxt = length_of(cfg.measure_minutes);
          end
        end
        default: begin
          phase_nxt     = PH_ZERO;
          remaining_nxt = length_of(cfg.zero_minutes);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ZERO;
      channel_r    <= CH_FIRST;
      remaining_r  <= length_of(MIN_RST);
      entered_r    <= 1'b0;
      zero_valve_r <= 1'b0;
      pump_r       <= 1'b0;
      valves_r     <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      channel_r    <= channel_nxt;
      remaining_r  <= remaining_nxt;
      entered_r    <= entered_nxt;
      zero_valve_r <= zero_valve_nxt;
      pump_r       <= pump_nxt;
      valves_r     <= valves_nxt;
    end
  end

  always_comb begin
    res.phase          = phase_nxt;
    res.channel        = channel_nxt;
    res.zero_valve     = zero_valve_nxt;
    res.pump_on        = pump_nxt;
    res.channel_valves = valves_nxt;
    res.seconds_left   = remaining_nxt;
    res.watchdog_kick  = kick;
    res.phase_done     = done;
  end

endmodule

`default_nettype wire

// File: rtl/gsps_oreg.sv
`default_nettype none

module gsps_oreg
  import gsps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  result_t   push_data,
  output logic      push_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    drain;

  // output register free this cycle
  assign drain = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

// File: rtl/gsps_checker.sv
`default_nettype none

module gsps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_channel,
  input wire logic [5:0]  out_channel_valves,
  input wire logic [15:0] out_seconds_left,
  input wire logic        out_watchdog_kick,
  input wire logic        out_phase_done
);

  // a word cannot both end a phase and kick the watchdog
  a_kick_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_watchdog_kick && out_phase_done))
    else $error("kick and phase_done together");

  // at most one sampling point valve open
  a_valves_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_channel_valves))
    else $error("more than one channel valve open");

  // selected channel stays within the sampling points
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_channel != 3'd0 && out_channel != 3'd7))
    else $error("channel out of range");

  // backpressure to the source only while a result word is held
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result held");

  // stalled result stays valid and keeps its seconds count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_seconds_left)))
    else $error("stalled result changed");

endmodule

bind gas_sampling_phase_sequencer gsps_checker u_gsps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_channel        (out_ch.channel),
  .out_channel_valves (out_ch.channel_valves),
  .out_seconds_left   (out_ch.seconds_left),
  .out_watchdog_kick  (out_ch.watchdog_kick),
  .out_phase_done     (out_ch.phase_done)
);

`default_nettype wire

// File: tb/gas_sampling_phase_sequencer_tb.sv
`timescale 1ns / 1ps

module gas_sampling_phase_sequencer_tb;
  import gsps_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 440;

  // ---------------------------------------------------------------------------
  // sequencer predictor and expected result words
  // ---------------------------------------------------------------------------
  class sequencer_checker;
    // register copy; minutes are kept in phase order, zero through stop
    logic [CH_W-1:0]  ch_count;
    logic [MIN_W-1:0] phase_minutes [5];

    // sequencer state
    phase_t           cur_phase;
    logic [CH_W-1:0]  channel;
    logic [SEC_W-1:0] secs_left;
    logic             entered;
    logic             zero_valve;
    logic             pump;
    logic [VLV_W-1:0] valves;

    result_t expected_words [$];
    int      errors;
    int      words_checked;
    int      phase_ends;
    int      kicks;
    int      reg_writes;

    function void reset_state();
      ch_count = CH_COUNT_RST;
      foreach (phase_minutes[i]) phase_minutes[i] = MIN_RST;
      cur_phase  = PH_ZERO;
      channel    = CH_FIRST;
      secs_left  = '0;
      entered    = 1'b0;
      zero_valve = 1'b0;
      pump       = 1'b0;
      valves     = '0;
      expected_words.delete();
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      reg_writes++;
      if (idx == REG_CHANNEL_COUNT) begin
        ch_count = value[CH_W-1:0];
        if (ch_count < 1) ch_count = 1;
        if (ch_count > MAX_CHANNELS_DEF) ch_count = CH_W'(MAX_CHANNELS_DEF);
      end else begin
        // minutes registers follow the phase order, one index above the phase code
        phase_minutes[int'(idx) - 1] = value[MIN_W-1:0];
      end
    endfunction

    // switch to a phase and load its full length in seconds
    function void enter_phase(phase_t p);
      cur_phase = p;
      secs_left = SEC_W'(int'(phase_minutes[int'(p)]) * SEC_PER_MIN);
    endfunction

    function void note_evaluation(logic tick);
      result_t          w;
      logic             kick;
      logic             done;
      logic [VLV_W-1:0] sel;
      kick = 1'b0;
      done = 1'b0;
      sel  = VLV_W'(1) << (channel - CH_W'(1));
      if (secs_left != 0) begin
        // first evaluation drives the phase outputs, later ones kick the watchdog
        if (!entered) begin
          case (cur_phase)
            PH_ZERO, PH_PURGE: begin
              zero_valve = 1'b1;
              pump       = 1'b1;
            end
            PH_MEASURE: begin
              valves = valves | sel;
              pump   = 1'b1;
            end
            default: begin
              zero_valve = 1'b0;
              pump       = 1'b0;
            end
          endcase
          entered = 1'b1;
        end else begin
          kick = 1'b1;
        end
        if (tick) secs_left = secs_left - 1'b1;
      end else begin
        // counter ran out: close up and move on, a tick here is dropped
        done    = 1'b1;
        entered = 1'b0;
        case (cur_phase)
          PH_ZERO: begin
            zero_valve = 1'b0;
            pump       = 1'b0;
            enter_phase(PH_MEASURE);
          end
          PH_MEASURE: begin
            valves = valves & ~sel;
            pump   = 1'b0;
            enter_phase(PH_PURGE);
          end
          PH_PURGE: begin
            zero_valve = 1'b0;
            pump       = 1'b0;
            enter_phase(PH_PAUSE);
          end
          PH_PAUSE: begin
            if (channel >= ch_count) begin
              channel = CH_FIRST;
              enter_phase(PH_STOP);
            end else begin
              channel = channel + 1'b1;
              enter_phase(PH_MEASURE);
            end
          end
          default: begin
            enter_phase(PH_ZERO);
          end
        endcase
      end
      w.phase          = cur_phase;
      w.channel        = channel;
      w.zero_valve     = zero_valve;
      w.pump_on        = pump;
      w.channel_valves = valves;
      w.seconds_left   = secs_left;
      w.watchdog_kick  = kick;
      w.phase_done     = done;
      expected_words.push_back(w);
    endfunction

    function string show(result_t w);
      return $sformatf("ph=%0d ch=%0d zv=%0b pump=%0b vlv=%b sec=%0d kick=%0b done=%0b",
                       w.phase, w.channel, w.zero_valve, w.pump_on, w.channel_valves,
                       w.seconds_left, w.watchdog_kick, w.phase_done);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (want.phase_done) phase_ends++;
      if (want.watchdog_kick) kicks++;
      if (got.phase !== want.phase || got.channel !== want.channel ||
          got.zero_valve !== want.zero_valve || got.pump_on !== want.pump_on ||
          got.channel_valves !== want.channel_valves ||
          got.seconds_left !== want.seconds_left ||
          got.watchdog_kick !== want.watchdog_kick ||
          got.phase_done !== want.phase_done) begin
        errors++;
        if (errors <= 10)
          $display("result word %0d mismatch\n  expected %s\n  actual   %s",
                   words_checked, show(want), show(got));
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  gsps_in_if  in_if ();
  gsps_out_if out_if ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gas_sampling_phase_sequencer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sequencer_checker sb = new();

  // calm stretches: no gaps on the input, no stalls on the output
  logic calm;
  int   evals_sent;
  int   cycles;

  // ---------------------------------------------------------------------------
  // result side: random stalls, most short, a few long
  // ---------------------------------------------------------------------------
  int hold_left;

  always @(negedge clk) begin : out_stall
    int roll;
    if (!rst_n || calm) begin
      out_if.ready <= 1'b1;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 20) hold_left <= $urandom_range(1, 3);
      else if (roll < 24) hold_left <= $urandom_range(8, 30);
    end
  end

  // sample the result word at the edge that accepts it
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.phase          = out_if.phase;
      got.channel        = out_if.channel;
      got.zero_valve     = out_if.zero_valve;
      got.pump_on        = out_if.pump_on;
      got.channel_valves = out_if.channel_valves;
      got.seconds_left   = out_if.seconds_left;
      got.watchdog_kick  = out_if.watchdog_kick;
      got.phase_done     = out_if.phase_done;
      sb.check_result(got);
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one evaluation word; valid stays up when the next word follows back to back
  task automatic send_eval(input logic tick);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.tick  <= tick;
    do @(posedge clk); while (!in_if.ready);
    sb.note_evaluation(tick);
    evals_sent++;
  endtask

  // stop sending and let every expected word come back
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int random_items;
    int seg_len;
    int tick_pct;
    reg_idx_t idx;

    rst_n        = 1'b0;
    calm         = 1'b0;
    evals_sent   = 0;
    in_if.valid  = 1'b0;
    in_if.tick   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    sb.reset_state();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset lengths are all zero: every phase ends at its first evaluation,
    // one channel, so the loop is zero, measure, purge, pause, stop, zero
    for (int i = 0; i < 6; i++) send_eval(i[0]);
    settle();

    // channel count above the maximum clamps to six; walk up the channels
    cfg_write(REG_CHANNEL_COUNT, 32'd7);
    for (int i = 0; i < 14; i++) send_eval(~i[0]);
    settle();

    // count written as zero clamps to one while channel five is running,
    // so its pause ends in stop
    cfg_write(REG_CHANNEL_COUNT, 32'd0);
    for (int i = 0; i < 5; i++) send_eval(i[1]);
    settle();

    // random part: lengths of zero or one minute so that whole cycles fit,
    // count changes land at random points of the channel walk
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      cfg_write(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
      for (int r = int'(REG_ZERO_MIN); r <= int'(REG_STOP_MIN); r++) begin
        if ($urandom_range(0, 1) == 1) begin
          idx = reg_idx_t'(r);
          cfg_write(idx, ($urandom_range(0, 9) < 7) ? 32'd0 : 32'd1);
        end
      end
      calm     = ($urandom_range(0, 3) == 0);
      tick_pct = ($urandom_range(0, 3) == 0) ? 30 : 90;
      seg_len  = $urandom_range(20, 60);
      for (int i = 0; i < seg_len; i++) send_eval($urandom_range(0, 99) < tick_pct);
      random_items += seg_len;
      settle();
      calm = 1'b0;
    end

    // longest lengths everywhere; the running phase is at most a minute,
    // so the next phase loads its full length of 1023 minutes
    cfg_write(REG_CHANNEL_COUNT, 32'd6);
    for (int r = int'(REG_ZERO_MIN); r <= int'(REG_STOP_MIN); r++) begin
      idx = reg_idx_t'(r);
      cfg_write(idx, 32'd1023);
    end
    for (int i = 0; i < 70; i++) send_eval(1'b1);

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d evaluations after %0d register writes, %0d result words checked",
             evals_sent, sb.reg_writes, sb.words_checked);
    $display("%0d phase ends and %0d watchdog kicks, %0d mismatches",
             sb.phase_ends, sb.kicks, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
